### rtl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg
// Types and constants shared by the sorted min-priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W          = 32;
    localparam int COUNT_OUT_W      = 5;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] top_value;
        logic                      is_empty;
        logic [COUNT_OUT_W-1:0]    entry_count;
        logic                      rejected;
    } t_out_item;

    // operation broadcast to every cell
    typedef struct packed {
        logic                      push;
        logic                      pop;
        logic signed [VALUE_W-1:0] value;
    } t_cell_ctl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic                      valid;
        logic                      ins;
        logic signed [VALUE_W-1:0] value;
    } t_cell_link;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
    } t_cell_state;

endpackage

### rtl/sorted_min_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_min_priority_queue
// Min-priority queue held as a chain of sorting cells, smallest at cell 0.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid / o_in_stall  | i_in_item  (kind, value)
//  out     | output    | o_out_valid / i_out_stall| o_out_item (top, empty, count, rej)
//
//  One item per cycle unless stalled: every cell decides its next entry from
//  its own compare and its neighbors' combinationally; the result is registered
//  and appears the cycle after the transfer. Synchronous reset empties the queue.
//  Input stalls only while a result is held and the output side stalls.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue #(
    parameter int CAPACITY = smpq_pkg::DEFAULT_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  smpq_pkg::t_in_item i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output smpq_pkg::t_out_item o_out_item,
    input  logic               i_out_stall
);
    import smpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_cell_link  w_link [CAPACITY];
    t_cell_state w_next [CAPACITY];
    t_cell_ctl   w_ctl;

    logic          w_accept;
    logic          w_full;
    logic          w_is_push;
    logic          w_is_pop;
    logic          w_reject;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW+COUNT_OUT_W-1:0] w_count_ext;
    logic          r_out_valid;
    t_out_item     r_out_item;
    t_out_item     n_out_item;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = w_link[CAPACITY-1].valid;
    assign w_is_push  = w_accept && (i_in_item.kind == KIND_PUSH);
    assign w_is_pop   = w_accept && (i_in_item.kind == KIND_POP);
    assign w_reject   = w_is_push && w_full;

    assign w_ctl = '{push: w_is_push && !w_full,
                     pop:  w_is_pop && w_link[0].valid,
                     value: i_in_item.value};

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_cell_link w_left;
        t_cell_link w_right;

        if (gi == 0) begin : g_first
            assign w_left = '{valid: 1'b1, ins: 1'b0, value: '0};
        end else begin : g_mid
            assign w_left = w_link[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign w_right = '{valid: 1'b0, ins: 1'b1, value: '0};
        end else begin : g_inner
            assign w_right = w_link[gi+1];
        end

        smpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_link  (w_link[gi]),
            .o_next  (w_next[gi])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctl.push) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_count_ext = {{COUNT_OUT_W{1'b0}}, n_count};

    always_comb begin
        n_out_item.top_value   = w_next[0].valid ? w_next[0].value : '0;
        n_out_item.is_empty    = !w_next[0].valid;
        n_out_item.entry_count = w_count_ext[COUNT_OUT_W-1:0];
        n_out_item.rejected    = w_reject;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### rtl/smpq_cell.sv
// ----------------------------------------------------------------------------
// smpq_cell
// One slot of the sorted list: holds an entry and moves it left or right.
// ----------------------------------------------------------------------------
module smpq_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  smpq_pkg::t_cell_ctl  i_ctl,
    input  smpq_pkg::t_cell_link i_left,
    input  smpq_pkg::t_cell_link i_right,
    output smpq_pkg::t_cell_link o_link,
    output smpq_pkg::t_cell_state o_next
);
    import smpq_pkg::*;

    logic                      r_valid;
    logic signed [VALUE_W-1:0] r_value;
    logic                      n_valid;
    logic signed [VALUE_W-1:0] n_value;
    logic                      w_ins;

    // insertion point is the first slot that is empty or holds a larger value
    assign w_ins = !r_valid || (r_value > i_ctl.value);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctl.push) begin
            if (i_left.ins) begin
                n_valid = i_left.valid;
                n_value = i_left.value;
            end else if (w_ins) begin
                n_valid = 1'b1;
                n_value = i_ctl.value;
            end
        end else if (i_ctl.pop) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link = '{valid: r_valid, ins: w_ins, value: r_value};
    assign o_next = '{valid: n_valid, value: n_value};

endmodule

### rtl/smpq_chk.sv
// ----------------------------------------------------------------------------
// smpq_chk
// Port-level checks for the sorted min-priority queue, bound to the top.
// ----------------------------------------------------------------------------
module smpq_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input smpq_pkg::t_out_item o_out_item,
    input logic                i_out_stall
);
    import smpq_pkg::*;

    // a held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // an empty queue reports zero and a count of zero
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.is_empty |->
            (o_out_item.top_value == '0) && (o_out_item.entry_count == '0))
        else $error("empty queue shows data");

    // a refused push means the queue is full, never empty
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.rejected |-> !o_out_item.is_empty)
        else $error("reject while empty");

    // a transfer in always yields a result the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("missing result");

endmodule

bind sorted_min_priority_queue smpq_chk u_smpq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

### dv/tb_sorted_min_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_min_priority_queue
// Self-checking bench for the sorted min-priority queue. A directed table
// covers the empty, full and extreme-value cases. A long random run with a
// shifting push/pop mix then fills and drains the queue many times. Both
// channels idle and stall at random. A predictor holds its own sorted copy
// of the queue.
// ----------------------------------------------------------------------------
module tb_sorted_min_priority_queue;
    import smpq_pkg::*;

    localparam int CAP          = DEFAULT_CAPACITY;
    localparam int DIR_ROWS     = 25;
    localparam int RANDOM_ITEMS = 1500;
    // legit quiet stretches come only from random input gaps and output stalls
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam t_out_item NO_STATUS = '0;

    typedef struct packed {
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
        logic                      has_status;
        t_out_item                 status;
    } dir_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b0;

    logic signed [VALUE_W-1:0] held_values[$];
    t_out_item                 pending_status[$];
    dir_row_t                  dir_table[DIR_ROWS];

    int errors       = 0;
    int quiet_cycles = 0;
    int stall_left   = 0;
    bit no_idle      = 1'b0;

    sorted_min_priority_queue uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_item  (in_item),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_item (out_item),
        .i_out_stall(out_stall)
    );

    always #5 clk = ~clk;

    // Applies one push or pop to the shadow queue and returns the status.
    function automatic t_out_item apply_queue_op(input logic kind,
                                                 input logic signed [VALUE_W-1:0] value);
        t_out_item st;
        int        pos;
        st = '0;
        if (kind == KIND_PUSH) begin
            if (held_values.size() >= CAP) begin
                st.rejected = 1'b1;
            end else begin
                // equal values stay ahead of the new one
                pos = 0;
                while (pos < held_values.size() && held_values[pos] <= value) pos++;
                held_values.insert(pos, value);
            end
        end else if (held_values.size() > 0) begin
            void'(held_values.pop_front());
        end
        if (held_values.size() == 0) begin
            st.is_empty  = 1'b1;
            st.top_value = '0;
        end else begin
            st.is_empty  = 1'b0;
            st.top_value = held_values[0];
        end
        st.entry_count = COUNT_OUT_W'(held_values.size());
        return st;
    endfunction

    // Drives one item from a falling edge and returns at the falling edge
    // after its transfer.
    task automatic send_op(input logic kind, input logic signed [VALUE_W-1:0] value,
                           input logic has_status, input t_out_item status);
        int        gap;
        t_out_item st;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= {kind, value};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        st = apply_queue_op(kind, value);
        pending_status.push_back(has_status ? status : st);
        @(negedge clk);
    endtask

    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= !no_idle && ($urandom_range(0, 7) == 0);
        end
    end

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (out_valid && !out_stall) begin
            if (pending_status.size() == 0) begin
                errors++;
                $display("%0t: unexpected result top=%0d empty=%0b count=%0d rej=%0b",
                         $time, out_item.top_value, out_item.is_empty,
                         out_item.entry_count, out_item.rejected);
            end else begin
                want = pending_status.pop_front();
                if (out_item.top_value !== want.top_value
                        || out_item.is_empty !== want.is_empty
                        || out_item.entry_count !== want.entry_count
                        || out_item.rejected !== want.rejected) begin
                    errors++;
                    $display("%0t: expected top=%0d empty=%0b count=%0d rej=%0b,",
                             $time, want.top_value, want.is_empty, want.entry_count,
                             want.rejected,
                             " got top=%0d empty=%0b count=%0d rej=%0b",
                             out_item.top_value, out_item.is_empty,
                             out_item.entry_count, out_item.rejected);
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 4);
        end
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_sorted_min_priority_queue: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        dir_row_t                  row;
        logic                      kind;
        logic signed [VALUE_W-1:0] value;
        int                        push_pct;

        // kind, value, status given?, status (top, empty, count, rejected)
        dir_table[0]  = {KIND_POP,  32'sh0000_0000, 1'b1, {32'sh0, 1'b1, 5'd0, 1'b0}};
        dir_table[1]  = {KIND_PUSH, VMAX,           1'b1, {VMAX,   1'b0, 5'd1, 1'b0}};
        dir_table[2]  = {KIND_PUSH, VMIN,           1'b1, {VMIN,   1'b0, 5'd2, 1'b0}};
        dir_table[3]  = {KIND_PUSH, VMIN,           1'b1, {VMIN,   1'b0, 5'd3, 1'b0}};
        dir_table[4]  = {KIND_POP,  32'shFFFF_FFFF, 1'b1, {VMIN,   1'b0, 5'd2, 1'b0}};
        dir_table[5]  = {KIND_POP,  32'sh0000_0000, 1'b1, {VMAX,   1'b0, 5'd1, 1'b0}};
        dir_table[6]  = {KIND_POP,  VMAX,           1'b1, {32'sh0, 1'b1, 5'd0, 1'b0}};
        // fill to capacity with duplicates and alternating bit patterns
        dir_table[7]  = {KIND_PUSH, 32'sh0000_0005, 1'b0, NO_STATUS};
        dir_table[8]  = {KIND_PUSH, 32'shFFFF_FFFD, 1'b0, NO_STATUS};
        dir_table[9]  = {KIND_PUSH, 32'sh0000_0005, 1'b0, NO_STATUS};
        dir_table[10] = {KIND_PUSH, 32'sh5555_5555, 1'b0, NO_STATUS};
        dir_table[11] = {KIND_PUSH, 32'shAAAA_AAAA, 1'b0, NO_STATUS};
        dir_table[12] = {KIND_PUSH, VMAX,           1'b0, NO_STATUS};
        dir_table[13] = {KIND_PUSH, VMIN,           1'b0, NO_STATUS};
        dir_table[14] = {KIND_PUSH, 32'sh0000_0000, 1'b0, NO_STATUS};
        dir_table[15] = {KIND_PUSH, 32'shFFFF_FFFF, 1'b0, NO_STATUS};
        dir_table[16] = {KIND_PUSH, 32'sh0000_0001, 1'b0, NO_STATUS};
        dir_table[17] = {KIND_PUSH, 32'sh0000_0064, 1'b0, NO_STATUS};
        dir_table[18] = {KIND_PUSH, 32'shFFFF_FF9C, 1'b0, NO_STATUS};
        dir_table[19] = {KIND_PUSH, 32'sh0000_0005, 1'b0, NO_STATUS};
        dir_table[20] = {KIND_PUSH, 32'sh1234_5678, 1'b0, NO_STATUS};
        dir_table[21] = {KIND_PUSH, 32'shFEDC_BA98, 1'b0, NO_STATUS};
        dir_table[22] = {KIND_PUSH, 32'sh0000_0007, 1'b1, {VMIN, 1'b0, 5'd16, 1'b0}};
        // push when full is refused
        dir_table[23] = {KIND_PUSH, 32'sh0000_0003, 1'b1, {VMIN, 1'b0, 5'd16, 1'b1}};
        dir_table[24] = {KIND_POP,  32'sh0000_0000, 1'b0, NO_STATUS};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_table[i];
            send_op(row.kind, row.value, row.has_status, row.status);
        end

        push_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // shift the push/pop mix so the queue swings between empty and full
            if (n % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0: push_pct = 25;
                    1: push_pct = 50;
                    2: push_pct = 75;
                    default: push_pct = 92;
                endcase
                no_idle = ($urandom_range(0, 4) == 0);
            end
            kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
            case ($urandom_range(0, 9))
                0: value = VMIN;
                1: value = VMAX;
                2, 3, 4: value = int'($urandom_range(0, 8)) - 4;
                default: value = $urandom;
            endcase
            send_op(kind, value, 1'b0, NO_STATUS);
        end
        in_valid <= 1'b0;

        while (pending_status.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("tb_sorted_min_priority_queue: PASS");
        end else begin
            $display("tb_sorted_min_priority_queue: FAIL");
        end
        $finish;
    end

endmodule
